>>> hdl/bmp_rgb24_window_crop_core_defines.svh
// ----------------------------------------------------------------------------
// bmp_rgb24_window_crop_core_defines
// Assertion macros shared by the crop core modules.
// ----------------------------------------------------------------------------
`ifndef BMP_RGB24_WINDOW_CROP_CORE_DEFINES_SVH
`define BMP_RGB24_WINDOW_CROP_CORE_DEFINES_SVH

// property must hold at every clock edge outside reset
`define BMPCROP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// expression must never be true outside reset
`define BMPCROP_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

>>> hdl/bmpcrop_pkg.sv
// ----------------------------------------------------------------------------
// bmpcrop_pkg
// Shared types and constants of the 24-bit window crop core.
// ----------------------------------------------------------------------------
package bmpcrop_pkg;

   localparam int BYTE_W      = 8;
   localparam int DIM_W       = 13;  // source and window sizes
   localparam int OFS_W       = 12;  // window offsets
   localparam int SPAN_W      = 14;  // offset plus size
   localparam int POS_W       = 16;  // byte positions within a row
   localparam int PAD_W       = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int QPTR_W      = 2;
   localparam int QUEUE_DEPTH = 1 << QPTR_W;

   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

   // cycles the input is held off after a register write
   localparam logic [1:0] SETTLE_START = 2'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_CROP_LEFT     = 3'd2,
      CSR_CROP_TOP      = 3'd3,
      CSR_CROP_WIDTH    = 3'd4,
      CSR_CROP_HEIGHT   = 3'd5
   } csr_index_type;

   // one classified item, waiting for the byte expander
   typedef struct packed {
      logic              err;
      logic              row_last;
      logic              frame_last;
      logic [PAD_W-1:0]  pad_cnt;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> hdl/bmpcrop_req_if.sv
// ----------------------------------------------------------------------------
// bmpcrop_req_if
// Source byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmpcrop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;

   modport source (output valid, output pixel_byte, input ready);
   modport sink (input valid, input pixel_byte, output ready);
endinterface

>>> hdl/bmpcrop_rsp_if.sv
// ----------------------------------------------------------------------------
// bmpcrop_rsp_if
// Cropped byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmpcrop_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_padding;
   logic       row_end;
   logic       frame_end;
   logic       window_error;

   modport source (output valid, output out_byte, output is_padding, output row_end,
                   output frame_end, output window_error, input ready);
   modport sink (input valid, input out_byte, input is_padding, input row_end,
                 input frame_end, input window_error, output ready);
endinterface

>>> hdl/bmpcrop_queue.sv
// ----------------------------------------------------------------------------
// bmpcrop_queue
// Small command queue between the classifier and the byte expander.
// ----------------------------------------------------------------------------
`include "bmp_rgb24_window_crop_core_defines.svh"

module bmpcrop_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bmpcrop_pkg::cmd_type    push_cmd,
   input  logic                    pop,
   output bmpcrop_pkg::cmd_type    head,
   output bmpcrop_pkg::q_status_type status
);

   localparam int PW = bmpcrop_pkg::QPTR_W;
   localparam int CW = bmpcrop_pkg::QPTR_W + 1;

   bmpcrop_pkg::cmd_type mem_ff [bmpcrop_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CW'(bmpcrop_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + PW'(1)) : wr_ptr_ff;
      rd_ptr_in = pop ? PW'(rd_ptr_ff + PW'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CW'(count_ff + CW'(1));
      end else if (pop && !push) begin
         count_in = CW'(count_ff - CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `BMPCROP_ASSERT_NEVER(a_no_push_full, clock, reset, push && status.full, "queue overflow")
   `BMPCROP_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && status.empty, "queue underflow")

endmodule

>>> hdl/bmpcrop_front.sv
// ----------------------------------------------------------------------------
// bmpcrop_front
// Holds the registers, tracks the source column and row, and classifies
// each accepted byte into a command for the byte expander.
// ----------------------------------------------------------------------------
`include "bmp_rgb24_window_crop_core_defines.svh"

module bmpcrop_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [bmpcrop_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bmpcrop_pkg::CSR_DATA_W-1:0]       csr_wdata,
   bmpcrop_req_if.sink                              req_ch,
   input  bmpcrop_pkg::q_status_type                q_status,
   output logic                                     q_push,
   output bmpcrop_pkg::cmd_type                     q_cmd
);

   localparam int DW      = bmpcrop_pkg::DIM_W;
   localparam int OW      = bmpcrop_pkg::OFS_W;
   localparam int SW      = bmpcrop_pkg::SPAN_W;
   localparam int PW      = bmpcrop_pkg::POS_W;
   localparam int DIM_MAX = (1 << DW) - 1;
   localparam int EFF_W   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
   localparam int EFF_H   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
   localparam int COL_W   = $clog2(3 * EFF_W + 4);
   localparam int ROW_W   = (EFF_H > 1) ? $clog2(EFF_H) : 1;
   localparam int RW1     = ROW_W + 1;
   localparam logic [DW-1:0] W_MAX = EFF_W[DW-1:0];
   localparam logic [DW-1:0] H_MAX = EFF_H[DW-1:0];

   // register file
   logic [DW-1:0] src_width_ff, src_height_ff, crop_width_ff, crop_height_ff;
   logic [OW-1:0] crop_left_ff, crop_top_ff;

   // derived values, first stage
   logic [DW-1:0] sw_clamp, sh_clamp;
   logic [1:0]    sw3_lo, cw3_lo;
   logic [DW-1:0] sw_a_ff, sh_a_ff;
   logic [1:0]    spad_a_ff, cpad_a_ff;
   logic [PW-1:0] first_a_ff;
   logic [SW-1:0] span_a_ff, top_end_a_ff;
   logic          empty_a_ff;

   // derived values, second stage
   logic [COL_W-1:0] rb_sum;
   logic [COL_W-1:0] rb_b_ff, rb_m1_b_ff;
   logic [ROW_W-1:0] sh_m1_b_ff;
   logic [PW-1:0]    last_b_ff;
   logic [SW-1:0]    fend_b_ff;
   logic             bad_b_ff;

   // position state
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             err_rep_ff, err_rep_in;
   logic [1:0]       settle_ff, settle_in;

   // position as left by the last accepted item, before any realignment
   logic [COL_W-1:0] col_hold_ff, col_hold_in;
   logic [ROW_W-1:0] row_hold_ff, row_hold_in;
   logic             err_hold_ff, err_hold_in;

   logic          accept, err_hit, in_win, in_rows, in_cols;
   logic          col_wrap, row_wrap, col_over, row_over;
   logic [PW-1:0] col_p;
   logic [SW-1:0] row_p;
   logic [RW1-1:0] row_inc, row_t, row_hold_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= DW'(1);
         src_height_ff  <= DW'(1);
         crop_left_ff   <= '0;
         crop_top_ff    <= '0;
         crop_width_ff  <= DW'(1);
         crop_height_ff <= DW'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            bmpcrop_pkg::CSR_SOURCE_WIDTH:  src_width_ff   <= csr_wdata;
            bmpcrop_pkg::CSR_SOURCE_HEIGHT: src_height_ff  <= csr_wdata;
            bmpcrop_pkg::CSR_CROP_LEFT:     crop_left_ff   <= csr_wdata[OW-1:0];
            bmpcrop_pkg::CSR_CROP_TOP:      crop_top_ff    <= csr_wdata[OW-1:0];
            bmpcrop_pkg::CSR_CROP_WIDTH:    crop_width_ff  <= csr_wdata;
            bmpcrop_pkg::CSR_CROP_HEIGHT:   crop_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      sw_clamp = (src_width_ff == '0) ? DW'(1) :
                 (src_width_ff > W_MAX) ? W_MAX : src_width_ff;
      sh_clamp = (src_height_ff == '0) ? DW'(1) :
                 (src_height_ff > H_MAX) ? H_MAX : src_height_ff;
      // low two bits of 3*n
      sw3_lo = 2'(sw_clamp[1:0] + {sw_clamp[0], 1'b0});
      cw3_lo = 2'(crop_width_ff[1:0] + {crop_width_ff[0], 1'b0});
   end

   always_ff @(posedge clock) begin
      sw_a_ff      <= sw_clamp;
      sh_a_ff      <= sh_clamp;
      spad_a_ff    <= 2'(~sw3_lo + 2'd1);
      cpad_a_ff    <= 2'(~cw3_lo + 2'd1);
      first_a_ff   <= PW'({crop_left_ff, 1'b0}) + PW'(crop_left_ff);
      span_a_ff    <= SW'(crop_left_ff) + SW'(crop_width_ff);
      top_end_a_ff <= SW'(crop_top_ff) + SW'(crop_height_ff);
      empty_a_ff   <= (crop_width_ff == '0) || (crop_height_ff == '0);
   end

   assign rb_sum = COL_W'({sw_a_ff, 1'b0}) + COL_W'(sw_a_ff) + COL_W'(spad_a_ff);

   always_ff @(posedge clock) begin
      rb_b_ff    <= rb_sum;
      rb_m1_b_ff <= COL_W'(rb_sum - COL_W'(1));
      sh_m1_b_ff <= ROW_W'(sh_a_ff - DW'(1));
      last_b_ff  <= PW'(PW'({span_a_ff, 1'b0}) + PW'(span_a_ff) - PW'(1));
      fend_b_ff  <= SW'(top_end_a_ff - SW'(1));
      bad_b_ff   <= (span_a_ff > SW'(sw_a_ff)) || (top_end_a_ff > SW'(sh_a_ff));
   end

   assign req_ch.ready = (settle_ff == '0) && !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      col_p   = PW'(col_ff);
      row_p   = SW'(row_ff);
      in_rows = (row_p >= SW'(crop_top_ff)) && (row_p < top_end_a_ff);
      in_cols = (col_p >= first_a_ff) && (col_p <= last_b_ff);
      err_hit = bad_b_ff && !err_rep_ff;
      in_win  = !bad_b_ff && !empty_a_ff && in_rows && in_cols;

      q_push           = accept && (err_hit || in_win);
      q_cmd.err        = err_hit;
      q_cmd.data       = err_hit ? bmpcrop_pkg::PAD_BYTE : req_ch.pixel_byte;
      q_cmd.row_last   = !err_hit && (col_p == last_b_ff);
      q_cmd.frame_last = !err_hit && (row_p == fend_b_ff);
      q_cmd.pad_cnt    = cpad_a_ff;
   end

   always_comb begin
      col_wrap = (col_ff == rb_m1_b_ff);
      row_wrap = col_wrap && (row_ff == sh_m1_b_ff);
      row_inc  = RW1'(row_ff) + RW1'(1);
      // realignment after a register change, always from the unaligned position
      row_hold_inc = RW1'(row_hold_ff) + RW1'(1);
      col_over     = (col_hold_ff >= rb_b_ff);
      row_t        = col_over ? row_hold_inc : RW1'(row_hold_ff);
      row_over     = (SW'(row_t) >= SW'(sh_a_ff));

      col_in      = col_ff;
      row_in      = row_ff;
      err_rep_in  = err_rep_ff;
      col_hold_in = col_hold_ff;
      row_hold_in = row_hold_ff;
      err_hold_in = err_hold_ff;
      settle_in   = (settle_ff != '0) ? 2'(settle_ff - 2'd1) : settle_ff;
      if (csr_we) begin
         settle_in = bmpcrop_pkg::SETTLE_START;
      end

      if (settle_ff == 2'd1) begin
         col_in     = col_over ? '0 : col_hold_ff;
         row_in     = row_over ? '0 : row_t[ROW_W-1:0];
         err_rep_in = row_over ? 1'b0 : err_hold_ff;
      end else if (accept) begin
         col_in      = col_wrap ? '0 : COL_W'(col_ff + COL_W'(1));
         row_in      = !col_wrap ? row_ff : (row_wrap ? '0 : row_inc[ROW_W-1:0]);
         err_rep_in  = row_wrap ? 1'b0 : (err_hit || err_rep_ff);
         col_hold_in = col_in;
         row_hold_in = row_in;
         err_hold_in = err_rep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         err_rep_ff  <= 1'b0;
         col_hold_ff <= '0;
         row_hold_ff <= '0;
         err_hold_ff <= 1'b0;
         settle_ff   <= bmpcrop_pkg::SETTLE_START;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         err_rep_ff  <= err_rep_in;
         col_hold_ff <= col_hold_in;
         row_hold_ff <= row_hold_in;
         err_hold_ff <= err_hold_in;
         settle_ff   <= settle_in;
      end
   end

   `BMPCROP_ASSERT(a_col_in_row, clock, reset,
      (settle_ff == '0) |-> (col_ff < rb_b_ff), "column past row length")
   `BMPCROP_ASSERT(a_row_in_frame, clock, reset,
      (settle_ff == '0) |-> (row_ff <= sh_m1_b_ff), "row past frame height")

endmodule

>>> hdl/bmpcrop_back.sv
// ----------------------------------------------------------------------------
// bmpcrop_back
// Expands queued commands into output bytes, adding row padding after the
// last byte of each cropped row.
// ----------------------------------------------------------------------------
`include "bmp_rgb24_window_crop_core_defines.svh"

module bmpcrop_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bmpcrop_pkg::cmd_type        head,
   input  bmpcrop_pkg::q_status_type   q_status,
   output logic                        q_pop,
   bmpcrop_rsp_if.source               rsp_ch
);

   localparam int BW = bmpcrop_pkg::BYTE_W;
   localparam int AW = bmpcrop_pkg::PAD_W;

   logic [AW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] out_byte_ff, out_byte_in;
   logic          is_padding_ff, is_padding_in;
   logic          row_end_ff, row_end_in;
   logic          frame_end_ff, frame_end_in;
   logic          window_error_ff, window_error_in;
   logic          load, emit, done;

   always_comb begin
      load = !rsp_valid_ff || rsp_ch.ready;
      emit = load && !q_status.empty;
      // plain bytes and error reports are one output each
      done = !head.row_last || (idx_ff == head.pad_cnt);
      q_pop = emit && done;

      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      out_byte_in     = out_byte_ff;
      is_padding_in   = is_padding_ff;
      row_end_in      = row_end_ff;
      frame_end_in    = frame_end_ff;
      window_error_in = window_error_ff;

      if (load) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         idx_in          = done ? '0 : AW'(idx_ff + AW'(1));
         out_byte_in     = (idx_ff == '0) ? head.data : bmpcrop_pkg::PAD_BYTE;
         is_padding_in   = (idx_ff != '0);
         row_end_in      = head.row_last && (idx_ff == head.pad_cnt);
         frame_end_in    = head.row_last && (idx_ff == head.pad_cnt) && head.frame_last;
         window_error_in = head.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff     <= out_byte_in;
      is_padding_ff   <= is_padding_in;
      row_end_ff      <= row_end_in;
      frame_end_ff    <= frame_end_in;
      window_error_ff <= window_error_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = out_byte_ff;
   assign rsp_ch.is_padding   = is_padding_ff;
   assign rsp_ch.row_end      = row_end_ff;
   assign rsp_ch.frame_end    = frame_end_ff;
   assign rsp_ch.window_error = window_error_ff;

   `BMPCROP_ASSERT(a_head_held, clock, reset,
      (idx_ff != '0) |-> !q_status.empty, "padding run lost its command")
   `BMPCROP_ASSERT(a_frame_on_row, clock, reset,
      (rsp_valid_ff && frame_end_ff) |-> row_end_ff, "frame end off a row end")

endmodule

>>> hdl/bmp_rgb24_window_crop_core.sv
// ----------------------------------------------------------------------------
// bmp_rgb24_window_crop_core
// Streaming window crop of row-padded 24-bit pixel data.
// ----------------------------------------------------------------------------
// Source bytes enter one per cycle in file order, unless held off; bytes
// inside the window (crop_left, crop_top, crop_width, crop_height) leave on
// the result channel, and each cropped row is closed with zero bytes up to
// a multiple of four. A classifier tracks the source column and row and
// writes one command per kept byte into a four-entry queue; an expander
// turns each command into one output byte, or into the byte plus up to three
// padding bytes at a row end, through a registered output. Input and output
// each run at one item per cycle unless held off or stalled; the last byte
// of a cropped row also emits its padding bytes, so rows whose width in bytes
// is not a multiple of four back up the queue. The input is held off while
// the queue is full and, after reset and any register write, while the
// window bounds are recomputed and the position counters realigned. A window
// over the source edge gives one window_error item per frame and nothing else.
// ----------------------------------------------------------------------------
module bmp_rgb24_window_crop_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bmpcrop_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bmpcrop_pkg::CSR_DATA_W-1:0]  csr_wdata,
   bmpcrop_req_if.sink                         req_ch,
   bmpcrop_rsp_if.source                       rsp_ch
);

   bmpcrop_pkg::cmd_type      push_cmd, head;
   bmpcrop_pkg::q_status_type q_status;
   logic                      q_push, q_pop;

   bmpcrop_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   bmpcrop_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (head),
      .status   (q_status)
   );

   bmpcrop_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
